// File: rtl/core/joint_torque_guard_plant_step_unit_defines.svh
// Assertion macros for the joint torque guard plant step unit.
// Used by the top level; expects clk and rst_n in scope.
`ifndef JOINT_TORQUE_GUARD_PLANT_STEP_UNIT_DEFINES_SVH
`define JOINT_TORQUE_GUARD_PLANT_STEP_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define JTG_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("jtg: invariant violated");
`define JTG_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jtg: implication violated");
`define JTG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jtg: next-cycle check violated");
`else
`define JTG_ASSERT_ALWAYS(lbl, expr)
`define JTG_ASSERT_IMPLIES(lbl, ante, cons)
`define JTG_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/core/jtg_pkg.sv
// Shared types, constants and the quarter-wave sine table for the joint
// torque guard plant step unit. No dependencies.
package jtg_pkg;

    localparam int SINE_DEPTH = 256;
    localparam int SINE_ABITS = $clog2(SINE_DEPTH);
    localparam int IDX_LSB    = 30 - SINE_ABITS;
    localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
    localparam logic [63:0] Q30_ONE        = 64'd1073741824;
    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;

    localparam int MUL_A_W = 38;
    localparam int MUL_B_W = 33;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int NET_W   = 54;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 27;

    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TORQUE = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_LIMIT = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VEL    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DT_INERTIA = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP  = 4'd7;

    localparam logic MODE_COMMAND = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE, S_PHASE, S_INTERP, S_GRAV, S_DAMP, S_DT, S_VEL, S_POS, S_ANGLE, S_OUT
    } state_t;

    typedef enum logic [2:0] {
        MS_PHASE, MS_INTERP, MS_GRAV, MS_DAMP, MS_DT, MS_POS
    } mul_sel_t;

    typedef struct packed {
        logic     store;
        logic     tick;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     sine_load;
        logic     net_load;
        logic     rate_load;
        logic     angle_load;
    } jtg_cmd_t;

    typedef logic [30:0] sine_tab_t [0:SINE_DEPTH];

    // Q30 samples of sin over a quarter wave, Taylor series to x^17.
    function automatic sine_tab_t build_sine_tab();
        sine_tab_t tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic signed [63:0] sum;
        for (int i = 0; i <= SINE_DEPTH; i++)
        begin
            x    = (HALF_PI_Q30 * 64'(i)) / SINE_DEPTH;
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            for (int k = 1; k <= 8; k++)
            begin
                term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
                if ((k & 1) != 0)
                    sum = sum - $signed(term);
                else
                    sum = sum + $signed(term);
            end
            if (sum < 0)
                sum = 0;
            if (sum > $signed(Q30_ONE))
                sum = $signed(Q30_ONE);
            tab[i] = 31'(sum);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

// File: rtl/core/joint_torque_guard_plant_step_unit.sv
// Top level of the joint torque guard plant step unit.
// Depends on jtg_pkg, jtg_ctrl, jtg_dp and the assertion macro header.
//
// One item at a time. A command item (tuser 0) stores the torque request and
// its result is offered on the next cycle. A tick item (tuser 1) runs the
// watchdog, torque clamp and soft limit, then one semi-implicit Euler step of
// the pendulum, in which six products pass in turn through one shared
// registered multiplier (phase, sine interpolation, gravity, damping,
// velocity, position) and the velocity and position updates have their own
// states. The input is ready again the cycle after the result is taken.
// Every item yields exactly one result showing the state.
// Configuration writes are taken at any time but must only happen while idle.
`include "joint_torque_guard_plant_step_unit_defines.svh"
module joint_torque_guard_plant_step_unit
    import jtg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // [23:0] torque_request
    input  logic                  s_tuser,   // [0] mode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [19:0] applied_torque, [51:20] position, [79:52] velocity,
    // [111:80] trip_count
    output logic [111:0]          m_tdata,
    output logic                  m_tuser,   // [0] guard_active
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    jtg_cmd_t           cmd;
    logic signed [19:0] applied_torque;
    logic signed [31:0] position;
    logic signed [27:0] velocity;
    logic [31:0]        trip_count;

    // sequence the item through the datapath
    jtg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_mode   (s_tuser),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd)
    );

    // hold plant state, guard state and configuration
    jtg_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .torque_request (s_tdata),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .applied_torque (applied_torque),
        .position       (position),
        .velocity       (velocity),
        .guard_active   (m_tuser),
        .trip_count     (trip_count)
    );

    // state is stable while the result waits, so present it directly
    assign m_tdata = {trip_count, velocity, position, applied_torque};

    `JTG_ASSERT_ALWAYS(a_one_side, !(s_tready && m_tvalid))
    `JTG_ASSERT_IMPLIES(a_guard_zero, m_tvalid && m_tuser, m_tdata[19:0] == 20'd0)
    `JTG_ASSERT_NEXT(a_single_result, m_tvalid && m_tready, !m_tvalid)

endmodule

// File: rtl/core/jtg_ctrl.sv
// Sequencing state machine for the joint torque guard plant step unit.
// Depends on jtg_pkg; drives jtg_dp through jtg_cmd_t.
module jtg_ctrl
    import jtg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_mode,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output jtg_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = (in_mode == MODE_COMMAND) ? S_OUT : S_PHASE;
            end
            S_PHASE:  state_next = S_INTERP;
            S_INTERP: state_next = S_GRAV;
            S_GRAV:   state_next = S_DAMP;
            S_DAMP:   state_next = S_DT;
            S_DT:     state_next = S_VEL;
            S_VEL:    state_next = S_POS;
            S_POS:    state_next = S_ANGLE;
            S_ANGLE:  state_next = S_OUT;
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd.mul_sel = MS_PHASE;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.store = in_valid && (in_mode == MODE_COMMAND);
            end
            S_PHASE:
            begin
                cmd.tick    = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_PHASE;
            end
            S_INTERP:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MS_INTERP;
                cmd.sine_load = 1'b1;
            end
            S_GRAV:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_GRAV;
            end
            S_DAMP:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MS_DAMP;
                cmd.net_load = 1'b1;
            end
            S_DT:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_DT;
            end
            S_VEL:    cmd.rate_load = 1'b1;
            S_POS:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_POS;
            end
            S_ANGLE:  cmd.angle_load = 1'b1;
            S_OUT:    out_valid = 1'b1;
            default:  cmd = '0;
        endcase
    end

endmodule

// File: rtl/core/jtg_dp.sv
// Datapath of the joint torque guard plant step unit: registers, guard
// logic, shared multiplier, sine lookup. Depends on jtg_pkg.
module jtg_dp
    import jtg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  jtg_cmd_t              cmd,
    input  logic signed [23:0]    torque_request,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic signed [19:0]    applied_torque,
    output logic signed [31:0]    position,
    output logic signed [27:0]    velocity,
    output logic                  guard_active,
    output logic [31:0]           trip_count
);

    logic [15:0] timeout_reg;
    logic [18:0] max_torque_reg;
    logic [26:0] soft_limit_reg;
    logic [26:0] max_vel_reg;
    logic [19:0] damping_reg;
    logic [19:0] gravity_reg;
    logic [23:0] dt_inertia_reg;
    logic [23:0] time_step_reg;

    logic signed [31:0] angle_reg;
    logic signed [27:0] rate_reg;
    logic signed [23:0] held_reg;
    logic signed [19:0] last_applied_reg;
    logic               seen_reg;
    logic [15:0]        age_reg;
    logic               guard_reg;
    logic [31:0]        trips_reg;
    logic signed [19:0] tau_reg;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [NET_W-1:0]  net_reg;
    logic [30:0]              lo_reg;
    logic                     neg_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg    <= 16'd50;
            max_torque_reg <= 19'd163840;
            soft_limit_reg <= 27'd20132659;
            max_vel_reg    <= 27'd67108864;
            damping_reg    <= 20'd7864;
            gravity_reg    <= 20'd36045;
            dt_inertia_reg <= 24'd209715;
            time_step_reg  <= 24'd16777;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TIMEOUT:    timeout_reg    <= cfg_data[15:0];
                REG_MAX_TORQUE: max_torque_reg <= cfg_data[18:0];
                REG_SOFT_LIMIT: soft_limit_reg <= cfg_data[26:0];
                REG_MAX_VEL:    max_vel_reg    <= cfg_data[26:0];
                REG_DAMPING:    damping_reg    <= cfg_data[19:0];
                REG_GRAVITY:    gravity_reg    <= cfg_data[19:0];
                REG_DT_INERTIA: dt_inertia_reg <= cfg_data[23:0];
                REG_TIME_STEP:  time_step_reg  <= cfg_data[23:0];
                default:        ;
            endcase
        end
    end

    // guard decision
    logic [15:0]        age_next;
    logic               stale;
    logic signed [23:0] tau_sel;
    logic signed [23:0] max_t;
    logic signed [23:0] tau_clamped;
    logic signed [32:0] angle_x;
    logic signed [32:0] soft_x;
    logic signed [19:0] tau_final;

    always_comb
    begin
        age_next    = (age_reg != 16'hFFFF) ? age_reg + 16'd1 : age_reg;
        stale       = !seen_reg || (age_next > timeout_reg);
        tau_sel     = stale ? 24'sd0 : held_reg;
        max_t       = $signed({5'b0, max_torque_reg});
        if (tau_sel > max_t)
            tau_clamped = max_t;
        else if (tau_sel < -max_t)
            tau_clamped = -max_t;
        else
            tau_clamped = tau_sel;
        angle_x = 33'(angle_reg);
        soft_x  = $signed({6'b0, soft_limit_reg});
        if ((angle_x >= soft_x && tau_clamped > 0) || (angle_x <= -soft_x && tau_clamped < 0))
            tau_final = 20'sd0;
        else
            tau_final = tau_clamped[19:0];
    end

    // sine lookup from the phase product
    logic [31:0]             phase;
    logic [30:0]             pos_q;
    logic [SINE_ABITS:0]     idx;
    logic [SINE_ABITS:0]     nxt;
    logic [30:0]             lo_val;
    logic [30:0]             hi_val;
    logic [30:0]             diff;
    logic [29:0]             frac;
    logic [31:0]             sine_mag;
    logic signed [31:0]      sine_val;

    always_comb
    begin
        phase  = prod_reg[55:24];
        pos_q  = phase[30] ? (31'h40000000 - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
        idx    = pos_q[30:IDX_LSB];
        nxt    = (idx < (SINE_ABITS+1)'(SINE_DEPTH)) ? idx + 1'b1 : idx;
        lo_val = SINE_TAB[idx];
        hi_val = SINE_TAB[nxt];
        diff   = (hi_val > lo_val) ? hi_val - lo_val : 31'd0;
        frac   = {pos_q[IDX_LSB-1:0], {SINE_ABITS{1'b0}}};
        sine_mag = {1'b0, lo_reg} + {1'b0, prod_reg[60:30]};
        sine_val = neg_reg ? -$signed(sine_mag) : $signed(sine_mag);
    end

    // shared multiplier operands
    logic signed [NET_W-1:0]   net_full;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;

    always_comb
    begin
        net_full = net_reg - NET_W'(prod_reg);
        case (cmd.mul_sel)
            MS_PHASE:
            begin
                mul_a = MUL_A_W'(angle_reg);
                mul_b = $signed({3'b0, INV_TWO_PI_Q32});
            end
            MS_INTERP:
            begin
                mul_a = $signed({7'b0, diff});
                mul_b = $signed({3'b0, frac});
            end
            MS_GRAV:
            begin
                mul_a = $signed({18'b0, gravity_reg});
                mul_b = MUL_B_W'(sine_val);
            end
            MS_DAMP:
            begin
                mul_a = $signed({18'b0, damping_reg});
                mul_b = MUL_B_W'(rate_reg);
            end
            MS_DT:
            begin
                mul_a = net_full[NET_W-1:16];
                mul_b = $signed({9'b0, dt_inertia_reg});
            end
            MS_POS:
            begin
                mul_a = MUL_A_W'(rate_reg);
                mul_b = $signed({9'b0, time_step_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            prod_reg <= mul_a * mul_b;
        if (cmd.sine_load)
        begin
            lo_reg  <= lo_val;
            neg_reg <= phase[31];
        end
        if (cmd.net_load)
            net_reg <= (NET_W'(tau_reg) <<< 24) - NET_W'(prod_reg >>> 6);
    end

    // velocity and position updates
    logic signed [47:0] rate_sum;
    logic signed [47:0] vmax;
    logic signed [27:0] rate_new;
    logic signed [33:0] pos_sum;
    logic signed [31:0] angle_new;

    always_comb
    begin
        rate_sum = 48'(rate_reg) + 48'(prod_reg >>> 24);
        vmax     = $signed({21'b0, max_vel_reg});
        if (rate_sum > vmax)
            rate_new = vmax[27:0];
        else if (rate_sum < -vmax)
            rate_new = 28'(-vmax);
        else
            rate_new = rate_sum[27:0];
        pos_sum = 34'(angle_reg) + $signed(prod_reg[57:24]);
        if (pos_sum > 34'sh07FFFFFFF)
            angle_new = 32'sh7FFFFFFF;
        else if (pos_sum < -34'sh080000000)
            angle_new = 32'sh80000000;
        else
            angle_new = pos_sum[31:0];
    end

    // plant and guard state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg        <= '0;
            rate_reg         <= '0;
            held_reg         <= '0;
            last_applied_reg <= '0;
            seen_reg         <= 1'b0;
            age_reg          <= '0;
            guard_reg        <= 1'b1;
            trips_reg        <= '0;
            tau_reg          <= '0;
        end
        else
        begin
            if (cmd.store)
            begin
                held_reg <= torque_request;
                seen_reg <= 1'b1;
                age_reg  <= '0;
            end
            if (cmd.tick)
            begin
                age_reg   <= age_next;
                guard_reg <= stale;
                tau_reg   <= tau_final;
                if (stale && seen_reg && !guard_reg)
                    trips_reg <= trips_reg + 32'd1;
            end
            if (cmd.rate_load)
                rate_reg <= rate_new;
            if (cmd.angle_load)
            begin
                angle_reg        <= angle_new;
                last_applied_reg <= tau_reg;
            end
        end
    end

    assign applied_torque = last_applied_reg;
    assign position       = angle_reg;
    assign velocity       = rate_reg;
    assign guard_active   = guard_reg;
    assign trip_count     = trips_reg;

endmodule
